>>> rtl/dwe_pkg.sv
package dwe_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_ENCODER = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;

   // register indexes on the csr port
   localparam int         CSR_INDEX_BITS  = 3;
   localparam logic [2:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [2:0] CSR_DUTY_MAX    = 3'd3;
   localparam logic [2:0] CSR_COUNT_SCALE = 3'd4;

   localparam int GAIN_BITS   = 20;
   localparam int DUTY_BITS   = 16;
   localparam int SCALE_BITS  = 8;
   localparam int CODE_BITS   = 4;
   localparam int CM_BITS     = 12;
   localparam int NOTCH_BITS  = 16;
   localparam int TARGET_BITS = 12;
   localparam int FRAC_BITS   = 16;

   localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RESET   = 20'd32768;
   localparam logic [GAIN_BITS-1:0]  INTEG_GAIN_RESET  = 20'd7;
   localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RESET  = 20'd6554;
   localparam logic [DUTY_BITS-1:0]  DUTY_MAX_RESET    = 16'd6000;
   localparam logic [SCALE_BITS-1:0] COUNT_SCALE_RESET = 8'd12;

   // speed codes and the duty / setpoint each one loads
   localparam logic [CODE_BITS-1:0] SPEED_SLOW = 4'd7;
   localparam logic [CODE_BITS-1:0] SPEED_MID  = 4'd8;
   localparam logic [CODE_BITS-1:0] SPEED_FAST = 4'd9;
   localparam logic [DUTY_BITS-1:0] DUTY_SLOW  = 16'd2400;
   localparam logic [DUTY_BITS-1:0] DUTY_MID   = 16'd3000;
   localparam logic [DUTY_BITS-1:0] DUTY_FAST  = 16'd4500;

   // target = floor((cm + 1) * 50 / 51), done as (cm + 1) * round_up(50 * 2^24 / 51) >> 24
   localparam int                   TARGET_MULT_BITS = 24;
   localparam logic [23:0]          TARGET_MULT      = 24'd16448251;
   localparam int                   TARGET_SHIFT     = 24;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef struct packed {
      logic [GAIN_BITS-1:0]  prop_gain;
      logic [GAIN_BITS-1:0]  integ_gain;
      logic [GAIN_BITS-1:0]  deriv_gain;
      logic [DUTY_BITS-1:0]  duty_max;
      logic [SCALE_BITS-1:0] count_scale;
   } cfg_type;

   typedef struct packed {
      logic                   ok;
      logic [DUTY_BITS-1:0]   duty;
   } speed_type;

   // classified item as it waits in the queue
   typedef struct packed {
      logic [1:0]             op;
      logic                   left_edge;
      logic                   right_edge;
      logic                   start_ok;
      logic [DUTY_BITS-1:0]   duty;
      logic [TARGET_BITS-1:0] target;
   } item_type;

   // per-item status carried down the back pipeline
   typedef struct packed {
      logic [1:0]             op;
      logic                   start_ok;
      logic [DUTY_BITS-1:0]   duty;
      logic                   run_done;
      logic                   start_ignored;
      logic                   drive_on;
      logic [NOTCH_BITS-1:0]  left_notches;
      logic [NOTCH_BITS-1:0]  right_notches;
   } info_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0]   left_duty;
      logic [DUTY_BITS-1:0]   right_duty;
      logic                   drive_on;
      logic                   run_done;
      logic                   start_ignored;
      logic [NOTCH_BITS-1:0]  left_notches;
      logic [NOTCH_BITS-1:0]  right_notches;
   } rsp_type;

   function automatic speed_type speed_lookup(input logic [CODE_BITS-1:0] code);
      speed_type s;
      s.ok   = 1'b1;
      s.duty = '0;
      unique case (code)
         SPEED_SLOW: s.duty = DUTY_SLOW;
         SPEED_MID:  s.duty = DUTY_MID;
         SPEED_FAST: s.duty = DUTY_FAST;
         default:    s.ok   = 1'b0;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/dual_wheel_encoder_pid_drive.sv
// two-wheel drive controller: start items (speed code 7, 8 or 9) load a duty and setpoint of
// 2400, 3000 or 4500, arm a run of floor((cm+1)*50/51) notches and turn the drive on; encoder
// items count notches per wheel, saturating and never cleared, and end the run once both
// counts pass the target; tick items run one pid step per wheel (q4.16 gains, saturating
// integral, output clamped to 0..duty_max). every item gives exactly one result item. the
// block takes one item per cycle while req_stall is low: a front stage classifies each item
// (speed table, target multiply) into a four-entry queue, and the back is a five-stage
// pipeline (counts and run, integral, gain multiplies, sum, clamp plus output register).
// rsp_stall holds the whole back and, once the queue is full, raises req_stall. csr writes
// are always ready and must be made while no item is in flight.
module dual_wheel_encoder_pid_drive
   import dwe_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int INTEGRAL_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic                      req_left_edge,
   input  logic                      req_right_edge,
   input  logic [CODE_BITS-1:0]      req_speed_code,
   input  logic [CM_BITS-1:0]        req_distance_cm,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [DUTY_BITS-1:0]      rsp_left_duty,
   output logic [DUTY_BITS-1:0]      rsp_right_duty,
   output logic                      rsp_drive_on,
   output logic                      rsp_run_done,
   output logic                      rsp_start_ignored,
   output logic [NOTCH_BITS-1:0]     rsp_left_notches,
   output logic [NOTCH_BITS-1:0]     rsp_right_notches,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [GAIN_BITS-1:0]      csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     push, queue_full, q_valid, q_pop;
   item_type push_item, q_item;
   rsp_type  rsp;

   // writes are registered straight into cfg_ff, so the port never pushes back
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROP_GAIN:   cfg_in.prop_gain   = csr_wdata;
            CSR_INTEG_GAIN:  cfg_in.integ_gain  = csr_wdata;
            CSR_DERIV_GAIN:  cfg_in.deriv_gain  = csr_wdata;
            CSR_DUTY_MAX:    cfg_in.duty_max    = csr_wdata[DUTY_BITS-1:0];
            CSR_COUNT_SCALE: cfg_in.count_scale = csr_wdata[SCALE_BITS-1:0];
            default: ;  // indexes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= PROP_GAIN_RESET;
         cfg_ff.integ_gain  <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain  <= DERIV_GAIN_RESET;
         cfg_ff.duty_max    <= DUTY_MAX_RESET;
         cfg_ff.count_scale <= COUNT_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: handshake and item classification
   dwe_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_left_edge   (req_left_edge),
      .req_right_edge  (req_right_edge),
      .req_speed_code  (req_speed_code),
      .req_distance_cm (req_distance_cm),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   // decouples the front from back-pressure on the result side
   dwe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .valid     (q_valid),
      .head      (q_item),
      .pop       (q_pop)
   );

   // back: state update and pid pipeline
   dwe_back #(
      .COUNT_BITS    (COUNT_BITS),
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_left_duty     = rsp.left_duty;
   assign rsp_right_duty    = rsp.right_duty;
   assign rsp_drive_on      = rsp.drive_on;
   assign rsp_run_done      = rsp.run_done;
   assign rsp_start_ignored = rsp.start_ignored;
   assign rsp_left_notches  = rsp.left_notches;
   assign rsp_right_notches = rsp.right_notches;

endmodule

>>> rtl/dwe_front.sv
module dwe_front
   import dwe_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic                 req_left_edge,
   input  logic                 req_right_edge,
   input  logic [CODE_BITS-1:0] req_speed_code,
   input  logic [CM_BITS-1:0]   req_distance_cm,
   input  logic                 queue_full,
   output logic                 push,
   output item_type             push_item
);

   speed_type                            speed;
   logic [CM_BITS:0]                     cm_plus;
   logic [CM_BITS+TARGET_MULT_BITS:0]    target_prod;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      speed       = speed_lookup(req_speed_code);
      cm_plus     = {1'b0, req_distance_cm} + 1'b1;
      target_prod = cm_plus * TARGET_MULT;

      push_item.op         = req_operation;
      push_item.left_edge  = req_left_edge;
      push_item.right_edge = req_right_edge;
      push_item.start_ok   = (req_operation == OP_START) && speed.ok;
      push_item.duty       = speed.duty;
      push_item.target     = target_prod[TARGET_SHIFT +: TARGET_BITS];
   end

endmodule

>>> rtl/dwe_queue.sv
module dwe_queue
   import dwe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     valid,
   output item_type head,
   input  logic     pop
);

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   fill_ff, fill_in;

   assign full  = fill_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign valid = fill_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/dwe_back.sv
module dwe_back
   import dwe_pkg::*;
#(
   parameter int COUNT_BITS    = 16,
   parameter int INTEGRAL_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   localparam int EW  = COUNT_BITS + SCALE_BITS + 1;
   localparam int DW  = EW + 1;
   localparam int GW  = GAIN_BITS + 1;
   localparam int PW  = GW + EW;
   localparam int DPW = GW + DW;
   localparam int IPW = GW + INTEGRAL_BITS;
   localparam int SW  = ((IPW > DPW) ? IPW : DPW) + 2;
   localparam int QW  = SW - FRAC_BITS;
   localparam int IAW = ((INTEGRAL_BITS > EW) ? INTEGRAL_BITS : EW) + 1;
   localparam int CW  = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   function automatic logic signed [INTEGRAL_BITS-1:0] integ_clip(
      input logic signed [IAW-1:0] v
   );
      logic signed [INTEGRAL_BITS-1:0] r;
      r = v[INTEGRAL_BITS-1:0];
      if (v[IAW-1] && !(&v[IAW-2:INTEGRAL_BITS-1])) begin
         r = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
      end else if (!v[IAW-1] && (|v[IAW-2:INTEGRAL_BITS-1])) begin
         r = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   logic advance;

   // stage 1 state: counts, run and setpoint
   logic [COUNT_BITS-1:0]          count_ff [2];
   logic [COUNT_BITS-1:0]          count_in [2];
   logic                           armed_ff, armed_in;
   logic                           drive_ff, drive_in;
   logic [TARGET_BITS-1:0]         target_ff, target_in;
   logic [DUTY_BITS-1:0]           setpoint_ff, setpoint_in;
   logic                           notch_seen [2];
   logic [COUNT_BITS+SCALE_BITS-1:0] scaled [2];
   logic signed [EW-1:0]           err [2];
   logic                           is_enc, start_go, hit, done;
   info_type                       s1_info_in;

   // stage 2 state: integrals and last errors
   logic signed [INTEGRAL_BITS-1:0] integ_ff [2];
   logic signed [EW-1:0]            last_ff [2];
   logic signed [IAW-1:0]           integ_sum [2];
   logic signed [INTEGRAL_BITS-1:0] integ_in [2];
   logic signed [DW-1:0]            diff [2];
   logic                            tick_go;

   // stage 3 products, stage 4 sums
   logic signed [PW-1:0]  prop_term [2];
   logic signed [DPW-1:0] deriv_term [2];
   logic signed [IPW-1:0] integ_term [2];
   logic signed [SW-1:0]  sum_in [2];

   // stage 5 clamp and duty state
   logic [QW-1:0]          quot [2];
   logic [DUTY_BITS-1:0]   clamp [2];
   logic [DUTY_BITS-1:0]   duty_ff [2];
   logic [DUTY_BITS-1:0]   duty_in [2];
   rsp_type                out_in;

   // pipeline registers
   logic                            s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                            out_valid_ff;
   info_type                        s1_info_ff, s2_info_ff, s3_info_ff, s4_info_ff;
   logic signed [EW-1:0]            s1_err_ff [2];
   logic signed [EW-1:0]            s2_err_ff [2];
   logic signed [DW-1:0]            s2_diff_ff [2];
   logic signed [INTEGRAL_BITS-1:0] s2_integ_ff [2];
   logic signed [PW-1:0]            s3_prop_ff [2];
   logic signed [DPW-1:0]           s3_deriv_ff [2];
   logic signed [IPW-1:0]           s3_integ_ff [2];
   logic signed [SW-1:0]            s4_sum_ff [2];
   rsp_type                         out_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign q_pop     = advance && q_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // stage 1: encoder counting, run control, speed error
   always_comb begin
      is_enc        = q_item.op == OP_ENCODER;
      start_go      = q_item.start_ok;
      notch_seen[0] = q_item.left_edge;
      notch_seen[1] = q_item.right_edge;
      for (int w = 0; w < 2; w++) begin
         count_in[w] = count_ff[w];
         if (is_enc && notch_seen[w] && count_ff[w] != COUNT_MAX) begin
            count_in[w] = count_ff[w] + 1'b1;
         end
         scaled[w] = count_ff[w] * cfg.count_scale;
         err[w]    = $signed(EW'(setpoint_ff)) - $signed(EW'(scaled[w]));
      end
      hit  = armed_ff && (CW'(count_in[0]) > CW'(target_ff))
                      && (CW'(count_in[1]) > CW'(target_ff));
      done = is_enc && hit;

      armed_in    = armed_ff;
      drive_in    = drive_ff;
      target_in   = target_ff;
      setpoint_in = setpoint_ff;
      if (start_go) begin
         armed_in    = 1'b1;
         drive_in    = 1'b1;
         target_in   = q_item.target;
         setpoint_in = q_item.duty;
      end else if (done) begin
         armed_in  = 1'b0;
         drive_in  = 1'b0;
         target_in = '0;
      end

      s1_info_in.op            = q_item.op;
      s1_info_in.start_ok      = start_go;
      s1_info_in.duty          = q_item.duty;
      s1_info_in.run_done      = done;
      s1_info_in.start_ignored = (q_item.op == OP_START) && !start_go;
      s1_info_in.drive_on      = drive_in;
      s1_info_in.left_notches  = NOTCH_BITS'(count_in[0]);
      s1_info_in.right_notches = NOTCH_BITS'(count_in[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         armed_ff    <= 1'b0;
         drive_ff    <= 1'b0;
         target_ff   <= '0;
         setpoint_ff <= '0;
      end else if (q_pop) begin
         count_ff    <= count_in;
         armed_ff    <= armed_in;
         drive_ff    <= drive_in;
         target_ff   <= target_in;
         setpoint_ff <= setpoint_in;
      end
   end

   // stage 2: integral with saturation, derivative from own last error
   always_comb begin
      tick_go = advance && s1_valid_ff && (s1_info_ff.op == OP_TICK);
      for (int w = 0; w < 2; w++) begin
         integ_sum[w] = IAW'(integ_ff[w]) + IAW'(s1_err_ff[w]);
         integ_in[w]  = integ_clip(integ_sum[w]);
         diff[w]      = DW'(s1_err_ff[w]) - DW'(last_ff[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         last_ff[0]  <= '0;
         last_ff[1]  <= '0;
      end else if (tick_go) begin
         integ_ff <= integ_in;
         last_ff  <= s1_err_ff;
      end
   end

   // stage 3 and 4: gain products, then their sum
   always_comb begin
      for (int w = 0; w < 2; w++) begin
         prop_term[w]  = $signed({1'b0, cfg.prop_gain}) * s2_err_ff[w];
         deriv_term[w] = $signed({1'b0, cfg.deriv_gain}) * s2_diff_ff[w];
         integ_term[w] = $signed({1'b0, cfg.integ_gain}) * s2_integ_ff[w];
         sum_in[w]     = SW'(s3_prop_ff[w]) + SW'(s3_deriv_ff[w]) + SW'(s3_integ_ff[w]);
      end
   end

   // stage 5: clamp to 0..duty_max and update the duty registers (clamp on ticks, start duty on accepted starts)
   always_comb begin
      for (int w = 0; w < 2; w++) begin
         quot[w] = s4_sum_ff[w][SW-1:FRAC_BITS];
         if (s4_sum_ff[w][SW-1] || s4_sum_ff[w] == '0) begin
            clamp[w] = '0;
         end else if (quot[w] > QW'(cfg.duty_max)) begin
            clamp[w] = cfg.duty_max;
         end else begin
            clamp[w] = quot[w][DUTY_BITS-1:0];
         end
         duty_in[w] = duty_ff[w];
         if (s4_info_ff.op == OP_TICK) begin
            duty_in[w] = clamp[w];
         end else if (s4_info_ff.start_ok) begin
            duty_in[w] = s4_info_ff.duty;
         end
      end
      out_in.left_duty     = duty_in[0];
      out_in.right_duty    = duty_in[1];
      out_in.drive_on      = s4_info_ff.drive_on;
      out_in.run_done      = s4_info_ff.run_done;
      out_in.start_ignored = s4_info_ff.start_ignored;
      out_in.left_notches  = s4_info_ff.left_notches;
      out_in.right_notches = s4_info_ff.right_notches;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff[0] <= '0;
         duty_ff[1] <= '0;
      end else if (advance && s4_valid_ff) begin
         duty_ff <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_info_ff  <= s1_info_in;
         s1_err_ff   <= err;
         s2_info_ff  <= s1_info_ff;
         s2_err_ff   <= s1_err_ff;
         s2_diff_ff  <= diff;
         s2_integ_ff <= integ_in;
         s3_info_ff  <= s2_info_ff;
         s3_prop_ff  <= prop_term;
         s3_deriv_ff <= deriv_term;
         s3_integ_ff <= integ_term;
         s4_info_ff  <= s3_info_ff;
         s4_sum_ff   <= sum_in;
         if (s4_valid_ff) begin
            out_ff <= out_in;
         end
      end
   end

endmodule

>>> rtl/dwe_checker.sv
module dwe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_left_duty,
   input logic [15:0] rsp_right_duty,
   input logic        rsp_drive_on,
   input logic        rsp_run_done,
   input logic        rsp_start_ignored,
   input logic [15:0] rsp_left_notches,
   input logic [15:0] rsp_right_notches
);

   // queue entries plus back pipeline stages plus output register
   localparam logic [3:0] MAX_IN_FLIGHT = 4'd9;

   logic [3:0] in_flight_ff, in_flight_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_take && !rsp_take) begin
         in_flight_in = in_flight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         in_flight_in = in_flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // a held result keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_duty)
         && $stable(rsp_right_duty) && $stable(rsp_drive_on) && $stable(rsp_run_done)
         && $stable(rsp_start_ignored) && $stable(rsp_left_notches)
         && $stable(rsp_right_notches))
      else $error("result item changed while stalled");

   // no result without an accepted item behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_flight_ff != '0)
      else $error("result item with no item in flight");

   // the queue and pipeline never hold more than their capacity
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= MAX_IN_FLIGHT)
      else $error("more items in flight than the block can hold");

   // a finished run stops the drive and is never a rejected start
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_done |-> !rsp_drive_on && !rsp_start_ignored)
      else $error("run done with drive still on or start flagged");

endmodule

bind dual_wheel_encoder_pid_drive dwe_checker u_checker (.*);
